// ----- rtl/mme_pkg.sv -----
// shared types and codes for the matrix multiply engine
package mme_pkg;

    // item kinds carried in the input tuser field
    typedef enum logic [1:0] {
        KIND_LOAD_A = 2'd0,
        KIND_LOAD_B = 2'd1,
        KIND_START  = 2'd2
    } kind_t;

    // configuration register indexes (paddr[3:2])
    localparam logic [1:0] REG_A_ROWS     = 2'd0;
    localparam logic [1:0] REG_INNER_SIZE = 2'd1;
    localparam logic [1:0] REG_B_COLS     = 2'd2;

    localparam int SIZE_REG_W = 4;
    localparam int FIELD_IDX_W = 3;
    localparam int IN_VALUE_W = 16;
    localparam int SUM_W = 36;
    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 48;

    // control that walks down the chain next to each A element
    typedef struct packed {
        logic valid;
        logic clear;
    } chain_ctl_t;

    // broadcast write of one B element into a column cell
    typedef struct packed {
        logic                   we;
        logic [FIELD_IDX_W-1:0] col;
    } b_wr_ctl_t;

endpackage

// ----- rtl/matrix_multiply_engine.sv -----
// top level of the matrix multiply engine
//
// Input stream (s_*): one beat per item. tuser holds the kind: load an A
// element, load a B element or start. Loads write row/col/value into the
// A store or into the B column of the matching cell; loads outside the
// store are dropped. A start beat multiplies the a_rows x inner_size A by
// the inner_size x b_cols B and sends the a_rows x b_cols result on the
// output stream (m_*) in row-major order, tlast on the final element.
// Sizes come from the APB registers; zero counts as one, values above
// MAX_DIM count as MAX_DIM. Write them only while the block is idle.
// For each result row the A elements stream through a chain of MAX_DIM
// column cells, one a cycle: inner_size feed steps, a drain through the
// chain and cell pipelines, then b_cols output beats. No input is taken
// from start until the last result is registered. A stalled receiver
// holds the output register and the row sequencer. Reset clears control
// state and sets every size register to 8; the stores hold nothing
// defined until written.
module matrix_multiply_engine #(
    parameter int MAX_DIM   = 8,
    parameter int ELEM_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // row[2:0], col[5:3], value[21:6], zero fill
    input  logic [mme_pkg::IN_DATA_W-1:0]     s_tdata,
    // kind[1:0]
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_row[2:0], out_col[5:3], product_value[41:6], zero fill
    output logic [mme_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [3:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import mme_pkg::*;

    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int DIM_CW  = $clog2(MAX_DIM + 1);
    localparam int A_DEPTH = 1 << (2 * DIM_W);
    localparam int DRAIN   = MAX_DIM + 4;
    localparam int DRN_W   = $clog2(DRAIN + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FEED  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [SIZE_REG_W-1:0] a_rows_reg, inner_size_reg, b_cols_reg;
    logic [DIM_CW-1:0]     m_dim, k_dim, n_dim;

    logic [DIM_W-1:0] i_reg, i_next;
    logic [DIM_W-1:0] x_reg, x_next;
    logic [DIM_W-1:0] j_reg, j_next;
    logic [DRN_W-1:0] drn_reg, drn_next;

    logic [FIELD_IDX_W-1:0] in_row, in_col;
    logic [IN_VALUE_W-1:0]  in_value;
    logic [ELEM_BITS-1:0]   in_elem;
    logic                   in_beat, in_range;
    kind_t                  in_kind;

    logic [ELEM_BITS-1:0] a_mem [A_DEPTH];
    logic [ELEM_BITS-1:0] a_rd_reg;
    logic [DIM_W-1:0]     feed_x_reg;
    chain_ctl_t           feed_ctl_reg;

    logic [ELEM_BITS-1:0] a_chain   [MAX_DIM+1];
    logic [DIM_W-1:0]     x_chain   [MAX_DIM+1];
    chain_ctl_t           ctl_chain [MAX_DIM+1];
    logic [SUM_W-1:0]     cell_acc  [MAX_DIM];
    b_wr_ctl_t            b_wr;

    logic                   last_col, last_row, last_x, emit_load;
    logic                   m_tvalid_reg;
    logic [FIELD_IDX_W-1:0] out_row_reg, out_col_reg;
    logic [SUM_W-1:0]       prod_val_reg;
    logic                   last_reg;

    // size register clamp to 1..MAX_DIM
    function automatic logic [DIM_CW-1:0] clamp_dim(input logic [SIZE_REG_W-1:0] r);
        logic [DIM_CW-1:0] d;
        if (r == '0)
            d = DIM_CW'(1);
        else if (32'(r) > MAX_DIM)
            d = DIM_CW'(MAX_DIM);
        else
            d = DIM_CW'(r);
        return d;
    endfunction

    assign m_dim = clamp_dim(a_rows_reg);
    assign k_dim = clamp_dim(inner_size_reg);
    assign n_dim = clamp_dim(b_cols_reg);

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg     <= SIZE_REG_W'(8);
            inner_size_reg <= SIZE_REG_W'(8);
            b_cols_reg     <= SIZE_REG_W'(8);
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_A_ROWS:     a_rows_reg     <= pwdata[SIZE_REG_W-1:0];
                REG_INNER_SIZE: inner_size_reg <= pwdata[SIZE_REG_W-1:0];
                REG_B_COLS:     b_cols_reg     <= pwdata[SIZE_REG_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_A_ROWS:     prdata = 32'(a_rows_reg);
            REG_INNER_SIZE: prdata = 32'(inner_size_reg);
            REG_B_COLS:     prdata = 32'(b_cols_reg);
            default:        prdata = '0;
        endcase
    end

    // input beat decode
    assign in_row   = s_tdata[2:0];
    assign in_col   = s_tdata[5:3];
    assign in_value = s_tdata[21:6];
    assign in_kind  = kind_t'(s_tuser);
    assign in_elem  = ELEM_BITS'(signed'(in_value));
    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign in_range = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);

    // A store, written by loads, read along a row while feeding
    always_ff @(posedge clk)
    begin
        if (in_beat && in_range && (in_kind == KIND_LOAD_A))
        begin
            a_mem[{DIM_W'(in_row), DIM_W'(in_col)}] <= in_elem;
        end
        a_rd_reg   <= a_mem[{i_reg, x_reg}];
        feed_x_reg <= x_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feed_ctl_reg <= '0;
        end
        else
        begin
            feed_ctl_reg.valid <= (state_reg == ST_FEED);
            feed_ctl_reg.clear <= (x_reg == '0);
        end
    end

    // B loads go to the column cell
    assign b_wr.we  = in_beat && in_range && (in_kind == KIND_LOAD_B);
    assign b_wr.col = in_col;

    // chain of column cells
    assign a_chain[0]   = a_rd_reg;
    assign x_chain[0]   = feed_x_reg;
    assign ctl_chain[0] = feed_ctl_reg;

    for (genvar c = 0; c < MAX_DIM; c++)
    begin : g_cell
        mme_cell #(
            .COL_IDX   (c),
            .DIM_W     (DIM_W),
            .ELEM_BITS (ELEM_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .b_wr      (b_wr),
            .b_wr_row  (DIM_W'(in_row)),
            .b_wr_data (in_elem),
            .a_in      (a_chain[c]),
            .x_in      (x_chain[c]),
            .ctl_in    (ctl_chain[c]),
            .a_out     (a_chain[c+1]),
            .x_out     (x_chain[c+1]),
            .ctl_out   (ctl_chain[c+1]),
            .acc       (cell_acc[c])
        );
    end

    // row sequencer
    assign last_x    = (32'(x_reg) == 32'(k_dim) - 1);
    assign last_col  = (32'(j_reg) == 32'(n_dim) - 1);
    assign last_row  = (32'(i_reg) == 32'(m_dim) - 1);
    assign emit_load = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        x_next     = x_reg;
        j_next     = j_reg;
        drn_next   = drn_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                i_next = '0;
                x_next = '0;
                if (in_beat && (in_kind == KIND_START))
                begin
                    state_next = ST_FEED;
                end
            end
            ST_FEED:
            begin
                x_next = x_reg + 1'b1;
                if (last_x)
                begin
                    x_next     = '0;
                    drn_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                drn_next = drn_reg + 1'b1;
                if (32'(drn_reg) == DRAIN - 1)
                begin
                    j_next     = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    j_next = j_reg + 1'b1;
                    if (last_col)
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = last_row ? ST_IDLE : ST_FEED;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            x_reg     <= '0;
            j_reg     <= '0;
            drn_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            x_reg     <= x_next;
            j_reg     <= j_next;
            drn_reg   <= drn_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            out_row_reg  <= FIELD_IDX_W'(i_reg);
            out_col_reg  <= FIELD_IDX_W'(j_reg);
            prod_val_reg <= cell_acc[j_reg];
            last_reg     <= last_col && last_row;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {6'b0, prod_val_reg, out_col_reg, out_row_reg};

    // checks
    a_emit_col: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (32'(j_reg) < 32'(n_dim)))
        else $error("result column past b_cols");

    a_feed_x: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FEED) |-> (32'(x_reg) < 32'(k_dim)))
        else $error("feed index past inner_size");

    a_beat_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("output beat outside result phase");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (32'(i_reg) < 32'(m_dim)))
        else $error("result row past a_rows");

endmodule

// ----- rtl/mme_cell.sv -----
// one column cell: holds a column of B and accumulates one result element
module mme_cell #(
    parameter int COL_IDX   = 0,
    parameter int DIM_W     = 3,
    parameter int ELEM_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mme_pkg::b_wr_ctl_t       b_wr,
    input  logic [DIM_W-1:0]         b_wr_row,
    input  logic [ELEM_BITS-1:0]     b_wr_data,
    input  logic [ELEM_BITS-1:0]     a_in,
    input  logic [DIM_W-1:0]         x_in,
    input  mme_pkg::chain_ctl_t      ctl_in,
    output logic [ELEM_BITS-1:0]     a_out,
    output logic [DIM_W-1:0]         x_out,
    output mme_pkg::chain_ctl_t      ctl_out,
    output logic [mme_pkg::SUM_W-1:0] acc
);
    import mme_pkg::*;

    localparam int DEPTH  = 1 << DIM_W;
    localparam int PROD_W = 2 * ELEM_BITS;
    localparam int EXT_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W;

    logic [ELEM_BITS-1:0]   b_mem [DEPTH];
    logic [ELEM_BITS-1:0]   b_rd_reg;
    logic [ELEM_BITS-1:0]   a_d_reg;
    logic [DIM_W-1:0]       x_d_reg;
    chain_ctl_t             ctl1_reg;
    chain_ctl_t             ctl2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [EXT_W-1:0]  prod_ext;
    logic [SUM_W-1:0]       acc_reg;

    // column store of B, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (b_wr.we && (32'(b_wr.col) == COL_IDX))
        begin
            b_mem[b_wr_row] <= b_wr_data;
        end
        b_rd_reg <= b_mem[x_in];
        a_d_reg  <= a_in;
        x_d_reg  <= x_in;
    end

    // product of the passing A element and this column's B element
    assign prod_next = PROD_W'(signed'(a_d_reg) * signed'(b_rd_reg));

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
        end
    end

    // accumulate modulo 2^SUM_W
    assign prod_ext = EXT_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (ctl2_reg.valid)
        begin
            if (ctl2_reg.clear)
            begin
                acc_reg <= prod_ext[SUM_W-1:0];
            end
            else
            begin
                acc_reg <= acc_reg + prod_ext[SUM_W-1:0];
            end
        end
    end

    // hand the element on to the next cell
    assign a_out   = a_d_reg;
    assign x_out   = x_d_reg;
    assign ctl_out = ctl1_reg;
    assign acc     = acc_reg;

endmodule
